### design/bea_pkg.sv
// ----------------------------------------------------------------------------
// bea_pkg: shared types and constants for the button event autorepeat block
// Field widths, event and register codes, lane codes and the button bit map.
// ----------------------------------------------------------------------------
`default_nettype none

package bea_pkg;

   localparam int unsigned BUTTON_COUNT_DEF = 8;
   localparam int unsigned BUTTON_MAX       = 8;

   localparam int unsigned RAW_W     = 16;
   localparam int unsigned RAW_IDX_W = 4;
   localparam int unsigned TRIG_W    = 8;
   localparam int unsigned TICK_W    = 32;
   localparam int unsigned DELAY_W   = 16;
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned IDX_W     = 3;
   localparam int unsigned VAL_W     = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_W     = 16;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REPEAT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TRIGGER = 3'd3;
   localparam logic [KIND_W-1:0] KIND_GRIP    = 3'd4;

   localparam logic [IDX_W-1:0] GRIP_INDEX    = 3'd4;
   localparam logic [IDX_W-1:0] TRIGGER_INDEX = 3'd5;

   localparam logic [VAL_W-1:0] GRIP_ON  = 8'hFF;
   localparam logic [VAL_W-1:0] GRIP_OFF = 8'h00;
   localparam logic [VAL_W-1:0] NO_VALUE = 8'h00;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_REPEAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEXT_REPEAT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HAND         = 2'd2;

   localparam logic [DELAY_W-1:0] FIRST_REPEAT_RESET = 16'd200;
   localparam logic [DELAY_W-1:0] NEXT_REPEAT_RESET  = 16'd100;

   typedef enum logic [1:0] {
      LANE_NONE    = 2'd0,
      LANE_PRESS   = 2'd1,
      LANE_RELEASE = 2'd2,
      LANE_REPEAT  = 2'd3
   } lane_code_type;

   typedef struct packed {
      logic [DELAY_W-1:0] first_repeat;
      logic [DELAY_W-1:0] next_repeat;
      logic               hand;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      logic [IDX_W-1:0]  button_index;
      logic              hand;
      logic [VAL_W-1:0]  analog_value;
      logic              last_event;
   } rsp_item_type;

   // raw word bit that carries each button
   function automatic logic [RAW_IDX_W-1:0] button_bit(input logic [IDX_W-1:0] idx);
      logic [RAW_IDX_W-1:0] b;
      case (idx)
         3'd0:    b = 4'd7;
         3'd1:    b = 4'd6;
         3'd2:    b = 4'd5;
         3'd3:    b = 4'd4;
         3'd4:    b = 4'd2;
         3'd5:    b = 4'd1;
         3'd6:    b = 4'd3;
         default: b = 4'd0;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

### design/bea_if.sv
// ----------------------------------------------------------------------------
// bea_if: poll and event channels
// Valid/ready channels carrying one poll or one button event per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bea_req_if;
   logic                          valid;
   logic                          ready;
   logic                          read_ok;
   logic [bea_pkg::RAW_W-1:0]     raw_buttons;
   logic [bea_pkg::TRIG_W-1:0]    trigger_level;
   logic [bea_pkg::TICK_W-1:0]    now_ticks;

   modport source (output valid, read_ok, raw_buttons, trigger_level, now_ticks,
                   input ready);
   modport sink   (input valid, read_ok, raw_buttons, trigger_level, now_ticks,
                   output ready);
endinterface

interface bea_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bea_pkg::KIND_W-1:0]    event_kind;
   logic [bea_pkg::IDX_W-1:0]     button_index;
   logic                          hand;
   logic [bea_pkg::VAL_W-1:0]     analog_value;
   logic                          last_event;

   modport source (output valid, event_kind, button_index, hand, analog_value,
                   last_event, input ready);
   modport sink   (input valid, event_kind, button_index, hand, analog_value,
                   last_event, output ready);
endinterface

`default_nettype wire

### design/button_event_autorepeat.sv
// ----------------------------------------------------------------------------
// button_event_autorepeat: button edge and autorepeat event generator
// One lane per button classifies each poll; a merge stage sends the events.
// ----------------------------------------------------------------------------
//  channel  | direction | item
//  ---------+-----------+-------------------------------------------------
//  req_ch   | in        | poll: read_ok, raw_buttons, trigger_level, now_ticks
//  rsp_ch   | out       | event: kind, button index, hand, analog value, last
//  csr_*    | in        | register write: index, data (no read-back)
//
//  a poll is classified by all lanes in the cycle it is taken; its events then
//  enter the output register one per cycle while rsp_ch does not stall, so a poll
//  with events (at most 10) holds req_ch while they wait and a poll with none does not
//  the next poll is taken in the cycle the last event of its predecessor enters
//  the output register
//  a stalled rsp_ch holds the event register and, while events wait, req_ch
//  reset is synchronous, clears held buttons and trigger and loads reset values into registers
// ----------------------------------------------------------------------------
`default_nettype none

module button_event_autorepeat #(
   parameter int unsigned BUTTON_COUNT = bea_pkg::BUTTON_COUNT_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   bea_req_if.sink                              req_ch,
   bea_rsp_if.source                            rsp_ch,
   input  wire                                  csr_we,
   input  wire  [bea_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [bea_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int unsigned LaneCount =
      (BUTTON_COUNT < bea_pkg::BUTTON_MAX) ? BUTTON_COUNT : bea_pkg::BUTTON_MAX;

   bea_pkg::cfg_type              cfg_ff, cfg_in;
   logic [bea_pkg::TRIG_W-1:0]    last_trig_ff, last_trig_in;
   logic                          accept;
   logic                          step;
   logic                          trig_hit;
   logic                          can_load;
   bea_pkg::lane_code_type        lane_code [LaneCount];
   bea_pkg::rsp_item_type         out_item;

   assign accept   = req_ch.valid & req_ch.ready;
   assign step     = accept & req_ch.read_ok;
   assign trig_hit = req_ch.trigger_level != last_trig_ff;
   assign req_ch.ready = can_load;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bea_pkg::CSR_FIRST_REPEAT: cfg_in.first_repeat = csr_wdata;
            bea_pkg::CSR_NEXT_REPEAT:  cfg_in.next_repeat  = csr_wdata;
            bea_pkg::CSR_HAND:         cfg_in.hand         = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
      last_trig_in = step ? req_ch.trigger_level : last_trig_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_repeat <= bea_pkg::FIRST_REPEAT_RESET;
         cfg_ff.next_repeat  <= bea_pkg::NEXT_REPEAT_RESET;
         cfg_ff.hand         <= 1'b0;
         last_trig_ff        <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         last_trig_ff <= last_trig_in;
      end
   end

   for (genvar g = 0; g < LaneCount; g++) begin : g_lane
      bea_lane #(
         .LaneIndex (g)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .step        (step),
         .raw_buttons (req_ch.raw_buttons),
         .now_ticks   (req_ch.now_ticks),
         .cfg         (cfg_ff),
         .code        (lane_code[g])
      );
   end

   bea_merge #(
      .LaneCount (LaneCount)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .trig_hit   (trig_hit),
      .trig_value (req_ch.trigger_level),
      .lane_code  (lane_code),
      .hand       (cfg_ff.hand),
      .can_load   (can_load),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_item   (out_item)
   );

   assign rsp_ch.event_kind   = out_item.event_kind;
   assign rsp_ch.button_index = out_item.button_index;
   assign rsp_ch.hand         = out_item.hand;
   assign rsp_ch.analog_value = out_item.analog_value;
   assign rsp_ch.last_event   = out_item.last_event;

endmodule

`default_nettype wire

### design/bea_lane.sv
// ----------------------------------------------------------------------------
// bea_lane: one button lane
// Tracks held state and repeat deadline of one button and classifies each poll.
// ----------------------------------------------------------------------------
`default_nettype none

module bea_lane #(
   parameter int unsigned LaneIndex = 0
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               step,
   input  wire  [bea_pkg::RAW_W-1:0]         raw_buttons,
   input  wire  [bea_pkg::TICK_W-1:0]        now_ticks,
   input  bea_pkg::cfg_type                  cfg,
   output bea_pkg::lane_code_type            code
);

   localparam logic [bea_pkg::RAW_IDX_W-1:0] BitPos =
      bea_pkg::button_bit(bea_pkg::IDX_W'(LaneIndex));

   logic                        held_ff, held_in;
   logic [bea_pkg::TICK_W-1:0]  deadline_ff, deadline_in;
   logic                        now_down;
   logic [bea_pkg::TICK_W-1:0]  since;
   logic                        due;

   assign now_down = raw_buttons[BitPos];
   // wrap-safe: due once now is at or past the deadline
   assign since    = now_ticks - deadline_ff;
   assign due      = ~since[bea_pkg::TICK_W-1];

   always_comb begin
      code        = bea_pkg::LANE_NONE;
      held_in     = held_ff;
      deadline_in = deadline_ff;
      if (now_down != held_ff) begin
         if (now_down) begin
            code        = bea_pkg::LANE_PRESS;
            deadline_in = now_ticks + bea_pkg::TICK_W'(cfg.first_repeat);
         end else begin
            code = bea_pkg::LANE_RELEASE;
         end
      end else if (now_down && due) begin
         code        = bea_pkg::LANE_REPEAT;
         deadline_in = now_ticks + bea_pkg::TICK_W'(cfg.next_repeat);
      end
      held_in = now_down;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= 1'b0;
         deadline_ff <= '0;
      end else if (step) begin
         held_ff     <= held_in;
         deadline_ff <= deadline_in;
      end
   end

endmodule

`default_nettype wire

### design/bea_merge.sv
// ----------------------------------------------------------------------------
// bea_merge: event merge and output stage
// Holds the events of one poll and sends them out one per cycle while out_ready allows.
// ----------------------------------------------------------------------------
`default_nettype none

module bea_merge #(
   parameter int unsigned LaneCount = bea_pkg::BUTTON_MAX
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               load,
   input  wire                               trig_hit,
   input  wire  [bea_pkg::TRIG_W-1:0]        trig_value,
   input  bea_pkg::lane_code_type            lane_code [LaneCount],
   input  wire                               hand,
   output logic                              can_load,
   output logic                              out_valid,
   input  wire                               out_ready,
   output bea_pkg::rsp_item_type             out_item
);

   logic                          trig_ff, trig_in;
   logic [bea_pkg::TRIG_W-1:0]    trig_val_ff, trig_val_in;
   bea_pkg::lane_code_type        code_ff [LaneCount];
   bea_pkg::lane_code_type        code_in [LaneCount];
   logic                          grip_ff, grip_in;
   logic [bea_pkg::VAL_W-1:0]     grip_val_ff, grip_val_in;
   logic                          out_valid_ff, out_valid_in;
   bea_pkg::rsp_item_type         item_ff, item_in;

   logic                          any_lane;
   logic                          found;
   logic [bea_pkg::IDX_W-1:0]     sel;
   bea_pkg::lane_code_type        sel_code;
   logic                          rest_any;
   logic                          pending;
   logic                          adv;
   logic                          last;

   // lowest lane with a pending event
   always_comb begin
      found    = 1'b0;
      sel      = '0;
      sel_code = bea_pkg::LANE_NONE;
      any_lane = 1'b0;
      for (int i = 0; i < LaneCount; i++) begin
         if (code_ff[i] != bea_pkg::LANE_NONE) begin
            any_lane = 1'b1;
            if (!found) begin
               found    = 1'b1;
               sel      = bea_pkg::IDX_W'(i);
               sel_code = code_ff[i];
            end
         end
      end
      rest_any = 1'b0;
      for (int i = 0; i < LaneCount; i++) begin
         if (code_ff[i] != bea_pkg::LANE_NONE && bea_pkg::IDX_W'(i) != sel) begin
            rest_any = 1'b1;
         end
      end
   end

   assign pending = trig_ff | grip_ff | any_lane;
   assign adv     = pending & (~out_valid_ff | out_ready);

   always_comb begin
      trig_in      = trig_ff;
      trig_val_in  = trig_val_ff;
      grip_in      = grip_ff;
      grip_val_in  = grip_val_ff;
      code_in      = code_ff;
      item_in      = item_ff;
      last         = 1'b0;
      out_valid_in = out_valid_ff & ~out_ready;

      if (adv) begin
         out_valid_in    = 1'b1;
         item_in.hand    = hand;
         if (trig_ff) begin
            trig_in              = 1'b0;
            last                 = ~any_lane;
            item_in.event_kind   = bea_pkg::KIND_TRIGGER;
            item_in.button_index = bea_pkg::TRIGGER_INDEX;
            item_in.analog_value = trig_val_ff;
         end else if (grip_ff) begin
            grip_in              = 1'b0;
            last                 = ~any_lane;
            item_in.event_kind   = bea_pkg::KIND_GRIP;
            item_in.button_index = bea_pkg::GRIP_INDEX;
            item_in.analog_value = grip_val_ff;
         end else begin
            item_in.button_index = sel;
            item_in.analog_value = bea_pkg::NO_VALUE;
            case (sel_code)
               bea_pkg::LANE_PRESS:   item_in.event_kind = bea_pkg::KIND_PRESS;
               bea_pkg::LANE_RELEASE: item_in.event_kind = bea_pkg::KIND_RELEASE;
               default:               item_in.event_kind = bea_pkg::KIND_REPEAT;
            endcase
            // grip edges are followed by a grip axis event
            if (sel == bea_pkg::GRIP_INDEX && sel_code != bea_pkg::LANE_REPEAT) begin
               grip_in     = 1'b1;
               grip_val_in = (sel_code == bea_pkg::LANE_PRESS) ?
                             bea_pkg::GRIP_ON : bea_pkg::GRIP_OFF;
            end
            last = ~rest_any &
                   ~(sel == bea_pkg::GRIP_INDEX && sel_code != bea_pkg::LANE_REPEAT);
            for (int i = 0; i < LaneCount; i++) begin
               if (bea_pkg::IDX_W'(i) == sel) begin
                  code_in[i] = bea_pkg::LANE_NONE;
               end
            end
         end
         item_in.last_event = last;
      end

      // new poll replaces a record that is empty or finishing now
      if (load) begin
         trig_in     = trig_hit;
         trig_val_in = trig_value;
         grip_in     = 1'b0;
         code_in     = lane_code;
      end
   end

   assign can_load  = ~pending | (adv & last);
   assign out_valid = out_valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff      <= 1'b0;
         grip_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < LaneCount; i++) begin
            code_ff[i] <= bea_pkg::LANE_NONE;
         end
      end else begin
         trig_ff      <= trig_in;
         grip_ff      <= grip_in;
         out_valid_ff <= out_valid_in;
         code_ff      <= code_in;
      end
      trig_val_ff <= trig_val_in;
      grip_val_ff <= grip_val_in;
      item_ff     <= item_in;
   end

endmodule

`default_nettype wire
